// ===== design/matrix_multiply_dot_product_macros.svh =====
// assertion macros used by the checker file
`ifndef MATRIX_MULTIPLY_DOT_PRODUCT_MACROS_SVH
`define MATRIX_MULTIPLY_DOT_PRODUCT_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define MMDP_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define MMDP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/mmdp_pkg.sv =====
// types and constants shared by the matrix dot product modules
package mmdp_pkg;

	localparam int IDX_W   = 6;
	localparam int VAL_W   = 16;
	localparam int PROD_W  = 32;
	localparam int DOT_W   = 38;
	localparam int DIM_W   = 7;
	localparam int QDEPTH  = 4;
	localparam int QAW     = 2;

	localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

	localparam logic [1:0] KIND_WR_A = 2'd0;
	localparam logic [1:0] KIND_WR_B = 2'd1;
	localparam logic [1:0] KIND_COMP = 2'd2;

	typedef enum logic [1:0] {
		OP_WR_A,
		OP_WR_B,
		OP_COMP,
		OP_ZERO
	} op_t;

	typedef struct packed {
		op_t                     op;
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [VAL_W-1:0] value;
	} entry_t;

endpackage

// ===== design/mmdp_front.sv =====
// front end: input and config handshakes, item classification, dimension register
module mmdp_front #(
	parameter int MAX_DIM = 64,
	parameter int NW      = 7
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          kind,
	input  logic [mmdp_pkg::IDX_W-1:0]          row_index,
	input  logic [mmdp_pkg::IDX_W-1:0]          col_index,
	input  logic signed [mmdp_pkg::VAL_W-1:0]   value,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mmdp_pkg::DIM_W-1:0]          cfg_data,
	input  logic                                q_full,
	output logic                                push,
	output mmdp_pkg::entry_t                    push_data,
	output logic [NW-1:0]                       eff_dim
);

	logic [mmdp_pkg::DIM_W-1:0] dim_q;
	logic                       accept;
	logic                       in_range;
	logic                       is_write;
	logic                       is_comp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q <= mmdp_pkg::DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			dim_q <= cfg_data;
		end
	end

	// clamp the configured dimension to 1..MAX_DIM
	always_comb begin
		if (dim_q == '0) begin
			eff_dim = NW'(1);
		end else if (9'(dim_q) > 9'(MAX_DIM)) begin
			eff_dim = NW'(MAX_DIM);
		end else begin
			eff_dim = NW'(dim_q);
		end
	end

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign in_range = (9'(row_index) < 9'(MAX_DIM)) && (9'(col_index) < 9'(MAX_DIM));
	assign is_write = (kind == mmdp_pkg::KIND_WR_A) || (kind == mmdp_pkg::KIND_WR_B);
	assign is_comp  = (kind == mmdp_pkg::KIND_COMP);

	// out-of-range writes and the unused kind are dropped here
	assign push = accept && ((is_write && in_range) || is_comp);

	always_comb begin
		push_data.row   = row_index;
		push_data.col   = col_index;
		push_data.value = value;
		case (kind)
			mmdp_pkg::KIND_WR_A: push_data.op = mmdp_pkg::OP_WR_A;
			mmdp_pkg::KIND_WR_B: push_data.op = mmdp_pkg::OP_WR_B;
			default:             push_data.op = in_range ? mmdp_pkg::OP_COMP : mmdp_pkg::OP_ZERO;
		endcase
	end

endmodule

// ===== design/mmdp_fifo.sv =====
// short command queue between the front end and the compute back end
module mmdp_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  mmdp_pkg::entry_t wr_data,
	output logic             full,
	input  logic             rd_en,
	output mmdp_pkg::entry_t rd_data,
	output logic             empty
);

	mmdp_pkg::entry_t            slot_q [mmdp_pkg::QDEPTH];
	logic [mmdp_pkg::QAW-1:0]    wr_ptr_q;
	logic [mmdp_pkg::QAW-1:0]    rd_ptr_q;
	logic [mmdp_pkg::QAW:0]      cnt_q;
	logic                        do_wr;
	logic                        do_rd;

	assign full    = (cnt_q == (mmdp_pkg::QAW+1)'(mmdp_pkg::QDEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + mmdp_pkg::QAW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + mmdp_pkg::QAW'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + (mmdp_pkg::QAW+1)'(1);
				2'b01:   cnt_q <= cnt_q - (mmdp_pkg::QAW+1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== design/mmdp_back.sv =====
// back end: element stores, multiply-accumulate walk and result register
module mmdp_back #(
	parameter int MAX_DIM = 64,
	parameter int NW      = 7
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  mmdp_pkg::entry_t                     head,
	input  logic                                 q_empty,
	output logic                                 pop,
	input  logic [NW-1:0]                        eff_dim,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [mmdp_pkg::DOT_W-1:0]    dot_product
);

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int KW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int MW    = AW + 10;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	state_t                                state_q;
	logic [KW-1:0]                         k_q;
	logic [mmdp_pkg::IDX_W-1:0]            row_q;
	logic [mmdp_pkg::IDX_W-1:0]            col_q;
	logic signed [mmdp_pkg::DOT_W-1:0]     acc_q;
	logic signed [mmdp_pkg::DOT_W-1:0]     dot_q;
	logic                                  out_valid_q;

	logic signed [mmdp_pkg::VAL_W-1:0]     mem_a [DEPTH];
	logic signed [mmdp_pkg::VAL_W-1:0]     mem_b [DEPTH];
	logic signed [mmdp_pkg::VAL_W-1:0]     a_rd_s1;
	logic signed [mmdp_pkg::VAL_W-1:0]     b_rd_s1;
	logic signed [mmdp_pkg::PROD_W-1:0]    prod_s2;
	logic                                  vld_s1;
	logic                                  vld_s2;

	logic [AW-1:0]                         wr_addr;
	logic [AW-1:0]                         a_addr;
	logic [AW-1:0]                         b_addr;
	logic                                  issue;
	logic                                  last;
	logic                                  out_free;
	logic                                  drained;

	assign pop      = (state_q == ST_IDLE) && !q_empty;
	assign issue    = (state_q == ST_RUN);
	assign last     = (NW'(k_q) == (eff_dim - NW'(1)));
	assign out_free = !out_valid_q || out_ready;
	assign drained  = !vld_s1 && !vld_s2;

	assign out_valid   = out_valid_q;
	assign dot_product = dot_q;

	// row-major addressing: A walks along its row, B walks down its column
	always_comb begin
		wr_addr = AW'(MW'(head.row) * MW'(MAX_DIM) + MW'(head.col));
		a_addr  = AW'(MW'(row_q) * MW'(MAX_DIM) + MW'(k_q));
		b_addr  = AW'(MW'(k_q) * MW'(MAX_DIM) + MW'(col_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			k_q         <= '0;
			row_q       <= '0;
			col_q       <= '0;
			acc_q       <= '0;
			dot_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (pop) begin
						row_q <= head.row;
						col_q <= head.col;
						k_q   <= '0;
						acc_q <= '0;
						case (head.op)
							mmdp_pkg::OP_COMP: state_q <= ST_RUN;
							mmdp_pkg::OP_ZERO: state_q <= ST_DRAIN;
							default:           state_q <= ST_IDLE;
						endcase
					end
				end
				ST_RUN: begin
					if (last) begin
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + KW'(1);
					end
				end
				ST_DRAIN: begin
					// wait for the last product to land, then for a free result slot
					if (drained && out_free) begin
						dot_q       <= acc_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (vld_s2) begin
				acc_q <= acc_q + mmdp_pkg::DOT_W'(prod_s2);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= issue;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && (head.op == mmdp_pkg::OP_WR_A)) begin
			mem_a[wr_addr] <= head.value;
		end
		if (pop && (head.op == mmdp_pkg::OP_WR_B)) begin
			mem_b[wr_addr] <= head.value;
		end
		a_rd_s1 <= mem_a[a_addr];
		b_rd_s1 <= mem_b[b_addr];
		prod_s2 <= a_rd_s1 * b_rd_s1;
	end

endmodule

// ===== design/matrix_multiply_dot_product.sv =====
// Square integer matrix multiplier that returns one entry of A x B per compute
// transaction. kind 0 and 1 store a signed 16-bit element of A or B at
// (row_index, col_index); kind 2 returns the sum over k below the configured
// dimension of A[row][k] * B[k][col] as a 38-bit two's complement value that
// wraps if it overflows; kind 3 is dropped. A compute whose row or column is
// MAX_DIM or more returns 0. The dimension register (reset 64) is written
// through cfg_valid/cfg_data; the user must write it only while the block is
// idle, and the block itself does not enforce this. 0 acts as 1 and values
// above MAX_DIM act as MAX_DIM. The two element stores hold MAX_DIM x MAX_DIM
// entries each, are not cleared by reset, and an element never written reads
// as an unknown value. A 4-entry queue sits between the input side and the
// compute side, so input transactions keep flowing while a compute runs until
// the queue fills. A write is stored as it is popped; a compute walks the row
// of A and column of B, one store read per cycle, through a single multiplier
// and accumulator, followed by the read, multiply and result-register stages.
module matrix_multiply_dot_product #(
	parameter int MAX_DIM = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          kind,
	input  logic [mmdp_pkg::IDX_W-1:0]          row_index,
	input  logic [mmdp_pkg::IDX_W-1:0]          col_index,
	input  logic signed [mmdp_pkg::VAL_W-1:0]   value,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mmdp_pkg::DIM_W-1:0]          cfg_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [mmdp_pkg::DOT_W-1:0]   dot_product
);

	localparam int NW = $clog2(MAX_DIM + 1);

	logic             q_full;
	logic             q_empty;
	logic             push;
	logic             pop;
	mmdp_pkg::entry_t push_data;
	mmdp_pkg::entry_t head;
	logic [NW-1:0]    eff_dim;

	mmdp_front #(
		.MAX_DIM (MAX_DIM),
		.NW      (NW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.row_index (row_index),
		.col_index (col_index),
		.value     (value),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data),
		.eff_dim   (eff_dim)
	);

	mmdp_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (push),
		.wr_data (push_data),
		.full    (q_full),
		.rd_en   (pop),
		.rd_data (head),
		.empty   (q_empty)
	);

	mmdp_back #(
		.MAX_DIM (MAX_DIM),
		.NW      (NW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_empty     (q_empty),
		.pop         (pop),
		.eff_dim     (eff_dim),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.dot_product (dot_product)
	);

endmodule

// ===== design/mmdp_checker.sv =====
// port-level checker for the matrix dot product block, bound to the top level
`include "matrix_multiply_dot_product_macros.svh"

module mmdp_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_ready,
	input logic [1:0]                   kind,
	input logic                         cfg_valid,
	input logic                         cfg_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic [mmdp_pkg::DOT_W-1:0]   dot_product
);

	logic [3:0] pend_q;
	logic       comp_in;
	logic       res_out;

	assign comp_in = in_valid && in_ready && (kind == mmdp_pkg::KIND_COMP);
	assign res_out = out_valid && out_ready;

	// computes accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			case ({comp_in, res_out})
				2'b10:   pend_q <= pend_q + 4'd1;
				2'b01:   pend_q <= pend_q - 4'd1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	`MMDP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(dot_product), "result changed or dropped while stalled")
	`MMDP_ASSERT_IMPL(a_no_orphan, out_valid, pend_q != 4'd0, "result without an outstanding compute")
	`MMDP_ASSERT_IMPL(a_pend_bound, 1'b1, pend_q <= 4'(mmdp_pkg::QDEPTH + 2), "more computes in flight than queue and stages hold")
	`MMDP_ASSERT_IMPL(a_cfg_ready, cfg_valid, cfg_ready, "config write stalled")

endmodule

bind matrix_multiply_dot_product mmdp_checker u_mmdp_checker (.*);

// ===== test/matrix_multiply_dot_product_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the matrix dot product block with a shadow copy of both stores
module matrix_multiply_dot_product_tb;

	localparam int IDX_W = mmdp_pkg::IDX_W;
	localparam int VAL_W = mmdp_pkg::VAL_W;
	localparam int DIM_W = mmdp_pkg::DIM_W;
	localparam int DOT_W = mmdp_pkg::DOT_W;

	localparam int MAX_DIM = 64;
	localparam int WATCH_LIMIT = 2000;
	localparam int DRAIN_CYCLES = MAX_DIM + 8;

	localparam logic [1:0] KIND_NONE = 2'd3;
	localparam logic [IDX_W-1:0] IDX_TOP = '1;
	localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
	localparam logic signed [VAL_W-1:0] VAL_MAX = ~VAL_MIN;

	// fill patterns for a row of A and a column of B
	localparam int FILL_RANDOM = 0;
	localparam int FILL_MOST_NEG = 1;
	localparam int FILL_MIXED_SIGN = 2;

	typedef struct packed {
		logic [1:0]              kind;
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [VAL_W-1:0] value;
	} mm_item_t;

	typedef struct packed {
		logic [1:0]              kind;
		logic [IDX_W-1:0]        row;
		logic [IDX_W-1:0]        col;
		logic signed [VAL_W-1:0] value;
		bit                      typed;
		logic signed [DOT_W-1:0] want;
	} directed_row_t;

	// run at dimension 0, which acts as 1: only column 0 of A and row 0 of B count
	localparam directed_row_t DIRECTED [20] = '{
		'{mmdp_pkg::KIND_WR_A, 6'd0, 6'd0, VAL_MIN, 1'b0, '0},
		'{mmdp_pkg::KIND_WR_B, 6'd0, 6'd0, VAL_MIN, 1'b0, '0},
		'{mmdp_pkg::KIND_COMP, 6'd0, 6'd0, '0, 1'b1, 38'sd1073741824},
		'{mmdp_pkg::KIND_WR_A, 6'd0, 6'd0, VAL_MAX, 1'b0, '0},
		'{mmdp_pkg::KIND_COMP, 6'd0, 6'd0, '0, 1'b1, -38'sd1073709056},
		'{mmdp_pkg::KIND_WR_B, 6'd0, IDX_TOP, VAL_MAX, 1'b0, '0},
		'{mmdp_pkg::KIND_COMP, 6'd0, IDX_TOP, '0, 1'b1, 38'sd1073676289},
		'{mmdp_pkg::KIND_WR_A, IDX_TOP, 6'd0, -16'sd1, 1'b0, '0},
		'{mmdp_pkg::KIND_COMP, IDX_TOP, IDX_TOP, '0, 1'b1, -38'sd32767},
		'{KIND_NONE, IDX_TOP, IDX_TOP, -16'sd1, 1'b0, '0},
		// stored beyond the dimension, must not change the sum
		'{mmdp_pkg::KIND_WR_A, IDX_TOP, IDX_TOP, VAL_MAX, 1'b0, '0},
		'{mmdp_pkg::KIND_WR_B, IDX_TOP, IDX_TOP, VAL_MIN, 1'b0, '0},
		'{mmdp_pkg::KIND_COMP, IDX_TOP, IDX_TOP, '0, 1'b1, -38'sd32767},
		'{mmdp_pkg::KIND_WR_A, 6'd0, 6'd0, 16'sd0, 1'b0, '0},
		'{mmdp_pkg::KIND_COMP, 6'd0, 6'd0, '0, 1'b1, 38'sd0},
		'{mmdp_pkg::KIND_WR_B, 6'd0, 6'd0, 16'sd21845, 1'b0, '0},
		'{mmdp_pkg::KIND_WR_A, 6'd0, 6'd0, -16'sd21846, 1'b0, '0},
		'{mmdp_pkg::KIND_COMP, 6'd0, 6'd0, '0, 1'b0, '0},
		'{KIND_NONE, 6'd0, 6'd0, 16'sd0, 1'b0, '0},
		'{mmdp_pkg::KIND_COMP, IDX_TOP, 6'd0, '0, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] kind = KIND_NONE;
	logic [IDX_W-1:0] row_index = '0;
	logic [IDX_W-1:0] col_index = '0;
	logic signed [VAL_W-1:0] value = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [DIM_W-1:0] cfg_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [DOT_W-1:0] dot_product;

	// shadow of the block
	logic signed [VAL_W-1:0] a_elem [MAX_DIM][MAX_DIM];
	logic signed [VAL_W-1:0] b_elem [MAX_DIM][MAX_DIM];
	bit a_known [MAX_DIM][MAX_DIM];
	bit b_known [MAX_DIM][MAX_DIM];
	logic [DIM_W-1:0] dim_reg = mmdp_pkg::DIM_RESET;
	logic signed [DOT_W-1:0] pending_dots [$];

	int seq_rows [$];
	int seq_cols [$];
	int items_sent = 0;
	int fails = 0;
	int quiet_cycles = 0;
	int ready_hold = 0;
	bit no_gaps = 1'b0;
	bit out_fire = 1'b0;
	logic signed [DOT_W-1:0] out_word;

	matrix_multiply_dot_product #(
		.MAX_DIM(MAX_DIM)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.row_index(row_index),
		.col_index(col_index),
		.value(value),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.dot_product(dot_product)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int eff_dim();
		if (dim_reg == 0) return 1;
		if (dim_reg > MAX_DIM) return MAX_DIM;
		return int'(dim_reg);
	endfunction

	function automatic logic signed [DOT_W-1:0] dot_of(input int r, input int c);
		longint acc;
		int n;
		acc = 0;
		n = eff_dim();
		if (r < MAX_DIM && c < MAX_DIM) begin
			for (int k = 0; k < n; k++)
				acc += longint'(a_elem[r][k]) * longint'(b_elem[k][c]);
		end
		return acc[DOT_W-1:0];
	endfunction

	// true when every element the sum would read has been written
	function automatic bit pair_ready(input int r, input int c);
		int n;
		n = eff_dim();
		for (int k = 0; k < n; k++)
			if (!a_known[r][k] || !b_known[k][c]) return 1'b0;
		return 1'b1;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 50);
	endfunction

	function automatic int pick_index();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 0;
		if (r == 1) return MAX_DIM - 1;
		return $urandom_range(0, MAX_DIM - 1);
	endfunction

	function automatic logic signed [VAL_W-1:0] fill_value(input int mode, input bit for_b);
		int r;
		logic signed [VAL_W-1:0] v;
		if (mode == FILL_MOST_NEG) return VAL_MIN;
		if (mode == FILL_MIXED_SIGN) return for_b ? VAL_MAX : VAL_MIN;
		r = $urandom_range(0, 99);
		v = VAL_W'($urandom);
		if (r < 10) v = VAL_MIN;
		else if (r < 20) v = VAL_MAX;
		else if (r < 25) v = '0;
		else if (r < 30) v = '1;
		return v;
	endfunction

	function automatic mm_item_t item_of(input logic [1:0] k, input int r, input int c,
			input logic signed [VAL_W-1:0] v);
		mm_item_t it;
		it.kind = k;
		it.row = IDX_W'(r);
		it.col = IDX_W'(c);
		it.value = v;
		return it;
	endfunction

	// one input transaction; updates the shadow stores once it is accepted
	task automatic push_item(input mm_item_t it, input bit typed = 1'b0,
			input logic signed [DOT_W-1:0] want = '0);
		int gap;
		bit rdy;
		gap = no_gaps ? 0 : gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= it.kind;
		row_index <= it.row;
		col_index <= it.col;
		value <= it.value;
		do begin
			@(negedge clk);
			rdy = in_ready;
			@(posedge clk);
		end while (!rdy);
		case (it.kind)
			mmdp_pkg::KIND_WR_A: begin
				a_elem[it.row][it.col] = it.value;
				a_known[it.row][it.col] = 1'b1;
			end
			mmdp_pkg::KIND_WR_B: begin
				b_elem[it.row][it.col] = it.value;
				b_known[it.row][it.col] = 1'b1;
			end
			mmdp_pkg::KIND_COMP: pending_dots.push_back(typed ? want : dot_of(it.row, it.col));
			default: ;
		endcase
		if (it.kind != KIND_NONE) items_sent++;
	endtask

	task automatic set_dimension(input logic [DIM_W-1:0] d);
		bit rdy;
		while (pending_dots.size() != 0) @(posedge clk);
		// trailing writes may still sit in the block's queue
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= d;
		do begin
			@(negedge clk);
			rdy = cfg_ready;
			@(posedge clk);
		end while (!rdy);
		cfg_valid <= 1'b0;
		dim_reg = d;
	endtask

	// fill a row of A and a column of B, then ask for their dot product
	task automatic run_sequence(input int mode);
		int n;
		int r;
		int c;
		n = eff_dim();
		r = pick_index();
		c = pick_index();
		for (int k = 0; k < n; k++)
			if (mode != FILL_RANDOM || !a_known[r][k] || $urandom_range(0, 1))
				push_item(item_of(mmdp_pkg::KIND_WR_A, r, k, fill_value(mode, 1'b0)));
		for (int k = 0; k < n; k++)
			if (mode != FILL_RANDOM || !b_known[k][c] || $urandom_range(0, 1))
				push_item(item_of(mmdp_pkg::KIND_WR_B, k, c, fill_value(mode, 1'b1)));
		seq_rows.push_back(r);
		seq_cols.push_back(c);
		repeat ($urandom_range(1, 3))
			push_item(item_of(mmdp_pkg::KIND_COMP, r, c, VAL_W'($urandom)));
	endtask

	task automatic noise_item();
		int p;
		int r;
		int c;
		p = $urandom_range(0, 99);
		if (p >= 50 && seq_rows.size() > 0) begin
			r = seq_rows[$urandom_range(0, seq_rows.size() - 1)];
			c = seq_cols[$urandom_range(0, seq_cols.size() - 1)];
			if (pair_ready(r, c)) begin
				push_item(item_of(mmdp_pkg::KIND_COMP, r, c, VAL_W'($urandom)));
				return;
			end
		end
		if (p >= 35 && p < 50)
			push_item(item_of(KIND_NONE, $urandom_range(0, MAX_DIM - 1),
				$urandom_range(0, MAX_DIM - 1), VAL_W'($urandom)));
		else
			push_item(item_of($urandom_range(0, 1) ? mmdp_pkg::KIND_WR_B : mmdp_pkg::KIND_WR_A,
				pick_index(), pick_index(), fill_value(FILL_RANDOM, 1'b0)));
	endtask

	task automatic run_phase(input int budget);
		int start;
		int seq_pct;
		start = items_sent;
		seq_pct = (eff_dim() > 16) ? 3 : 25;
		while (items_sent - start < budget) begin
			if ($urandom_range(0, 99) < seq_pct) run_sequence($urandom_range(0, 9) == 0 ?
				FILL_MIXED_SIGN : FILL_RANDOM);
			else noise_item();
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		logic [DIM_W-1:0] d;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset dimension first
		run_sequence(FILL_RANDOM);
		run_phase(10);

		set_dimension('0);
		foreach (DIRECTED[i])
			push_item(item_of(DIRECTED[i].kind, DIRECTED[i].row, DIRECTED[i].col,
				DIRECTED[i].value), DIRECTED[i].typed, DIRECTED[i].want);
		in_valid <= 1'b0;

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: d = '1;
				5: d = 7'd1;
				7: d = 7'(MAX_DIM);
				default: d = 7'($urandom_range(2, 16));
			endcase
			set_dimension(d);
			no_gaps = ($urandom_range(0, 3) == 0);
			// full-size sum of the most negative elements gives the largest result
			if (ph == 0) run_sequence(FILL_MOST_NEG);
			run_phase(eff_dim() > 16 ? 20 : 35);
		end

		while (pending_dots.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	always @(posedge clk) begin : result_side
		int g;
		logic signed [DOT_W-1:0] want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			ready_hold <= 0;
		end else begin
			if (out_fire) begin
				if (pending_dots.size() == 0) begin
					$error("dot_product: expected none, got %0d", out_word);
					fails++;
				end else begin
					want = pending_dots.pop_front();
					if (out_word !== want) begin
						$error("dot_product: expected %0d, got %0d", want, out_word);
						fails++;
					end
				end
			end
			if (ready_hold > 0) begin
				ready_hold <= ready_hold - 1;
			end else if (out_ready) begin
				g = no_gaps ? 0 : gap_len();
				if (g > 0) begin
					out_ready <= 1'b0;
					ready_hold <= g - 1;
				end else begin
					ready_hold <= $urandom_range(0, 30);
				end
			end else begin
				out_ready <= 1'b1;
				ready_hold <= $urandom_range(0, 30);
			end
		end
	end

	// sample between edges so nothing depends on event order at the clock edge
	always @(negedge clk) begin
		out_fire = out_valid && out_ready;
		out_word = dot_product;
		if (arst_n) begin
			if (out_fire || (in_valid && in_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCH_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

endmodule

// ===== matrix_multiply_dot_product.f =====
+incdir+design
design/mmdp_pkg.sv
design/mmdp_front.sv
design/mmdp_fifo.sv
design/mmdp_back.sv
design/matrix_multiply_dot_product.sv
design/mmdp_checker.sv
test/matrix_multiply_dot_product_tb.sv
